FILE: rtl/core/apfc_pkg.sv
// Package: fixed-point constants, register indexes and saturating helpers for the amplitude update.
`default_nettype none
package apfc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIV_BITS  = 49;

  localparam logic signed [17:0] ONE_Q      = 18'sd65536;
  localparam logic signed [17:0] HALF_Q     = 18'sd32768;
  localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_GROWTH     = 2'd1;
  localparam logic [1:0] REG_WAVE_STEP  = 2'd2;

  localparam logic [15:0] TIME_STEP_RST = 16'd2621;
  localparam logic [17:0] GROWTH_RST    = 18'd415;
  localparam logic [15:0] WAVE_STEP_RST = 16'd4096;

  localparam logic [1:0] MODE_K1 = 2'd0;
  localparam logic [1:0] MODE_K2 = 2'd1;
  localparam logic [1:0] MODE_K3 = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(MAX32)) return MAX32;
    if (v < 64'(MIN32)) return MIN32;
    return v[31:0];
  endfunction

  // round half up, then saturate
  function automatic logic signed [31:0] fmul_rs(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/apfc_spectral_amplitude_update.sv
// Top level: pipelined semi-implicit spectral amplitude update with restoring divider.
//
// channel   direction  ports                                              qualifier
// request   in         row/col_index, mode_select, amp_*, nonlin_*       start_i & !busy_o
// result    out        new_amp_real_o, new_amp_imag_o                     done_o
// config    in         cfg_idx_i, cfg_data_i                              cfg_we_i
//
// One request per cycle; busy_o is always low. The pipeline has eleven
// arithmetic stages and 49 restoring divider stages, one quotient bit each,
// then the output register. The pipeline never stalls, the receiver takes
// each result in its strobe cycle. Reset clears the valid chain and loads
// the register defaults.
`default_nettype none
module apfc_spectral_amplitude_update (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire         [5:0]   row_index_i,
  input  wire         [5:0]   col_index_i,
  input  wire         [1:0]   mode_select_i,
  input  wire  signed [31:0]  amp_real_i,
  input  wire  signed [31:0]  amp_imag_i,
  input  wire  signed [31:0]  nonlin_real_i,
  input  wire  signed [31:0]  nonlin_imag_i,
  input  wire                 cfg_we_i,
  input  wire         [1:0]   cfg_idx_i,
  input  wire         [17:0]  cfg_data_i,
  output logic                done_o,
  output logic signed [31:0]  new_amp_real_o,
  output logic signed [31:0]  new_amp_imag_o
);

  localparam int unsigned FRONT = 11;
  localparam int unsigned LAT   = FRONT + apfc_pkg::DIV_BITS + 1;
  localparam int unsigned DB    = apfc_pkg::DIV_BITS;

  logic [15:0] dt_q;
  logic [17:0] gam_q;
  logic [15:0] ws_q;

  logic acc;
  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= apfc_pkg::TIME_STEP_RST;
      gam_q <= apfc_pkg::GROWTH_RST;
      ws_q  <= apfc_pkg::WAVE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apfc_pkg::REG_TIME_STEP: dt_q  <= cfg_data_i[15:0];
        apfc_pkg::REG_GROWTH:    gam_q <= cfg_data_i;
        apfc_pkg::REG_WAVE_STEP: ws_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // valid chain: front stages, divider stages, output
  logic [FRONT-1:0] fv_q;
  logic [DB:1]      dv_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q   <= '0;
      dv_q   <= '0;
      done_q <= 1'b0;
    end else begin
      fv_q   <= {fv_q[FRONT-2:0], acc};
      dv_q   <= {dv_q[DB-1:1], fv_q[FRONT-1]};
      done_q <= dv_q[DB];
    end
  end
  assign done_o = done_q;

  // stage 1
  logic signed [21:0] kx1_q, ky1_q;
  logic signed [17:0] vx1_q, vy1_q;
  logic signed [31:0] ar1_q, ai1_q;
  logic signed [48:0] pr1_q, pi1_q;
  // stage 2
  logic signed [22:0] q1x2_q, q1y2_q;
  logic signed [21:0] kx2_q, ky2_q;
  logic signed [17:0] vx2_q, vy2_q;
  // numerator carried through front stages
  logic signed [31:0] nr_q [2:FRONT-1];
  logic signed [31:0] ni_q [2:FRONT-1];
  // stage 3
  logic signed [31:0] s1x3_q, s1y3_q, s0x3_q, s0y3_q, kqx3_q, kqy3_q;
  // stage 4
  logic signed [31:0] q1sq4_q, q0sq4_q, kq4_q;
  // stage 5..10
  logic signed [31:0] q1sq5_q, op5_q;
  logic signed [31:0] q1sq6_q, opsq6_q;
  logic signed [31:0] q1sq7_q, g7_q;
  logic signed [31:0] lin8_q, dtl9_q, den10_q;

  logic signed [17:0] vx_d, vy_d;
  always_comb begin
    case (mode_select_i)
      apfc_pkg::MODE_K1: begin vx_d = -apfc_pkg::SQRT3_HALF; vy_d = -apfc_pkg::HALF_Q; end
      apfc_pkg::MODE_K2: begin vx_d = '0; vy_d = apfc_pkg::ONE_Q; end
      apfc_pkg::MODE_K3: begin vx_d = apfc_pkg::SQRT3_HALF; vy_d = -apfc_pkg::HALF_Q; end
      default: begin vx_d = '0; vy_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    kx1_q <= $signed(col_index_i) * $signed({1'b0, ws_q});
    ky1_q <= $signed(row_index_i) * $signed({1'b0, ws_q});
    vx1_q <= vx_d;
    vy1_q <= vy_d;
    ar1_q <= amp_real_i;
    ai1_q <= amp_imag_i;
    pr1_q <= $signed({1'b0, dt_q}) * nonlin_real_i;
    pi1_q <= $signed({1'b0, dt_q}) * nonlin_imag_i;

    q1x2_q <= 23'(kx1_q) + 23'(vx1_q);
    q1y2_q <= 23'(ky1_q) + 23'(vy1_q);
    kx2_q  <= kx1_q;
    ky2_q  <= ky1_q;
    vx2_q  <= vx1_q;
    vy2_q  <= vy1_q;
    nr_q[2] <= apfc_pkg::sat32(64'(ar1_q) + 64'(apfc_pkg::fmul_rs(64'(pr1_q))));
    ni_q[2] <= apfc_pkg::sat32(64'(ai1_q) + 64'(apfc_pkg::fmul_rs(64'(pi1_q))));
    for (int k = 3; k < FRONT; k++) begin
      nr_q[k] <= nr_q[k-1];
      ni_q[k] <= ni_q[k-1];
    end

    s1x3_q <= apfc_pkg::fmul_rs(64'(q1x2_q) * 64'(q1x2_q));
    s1y3_q <= apfc_pkg::fmul_rs(64'(q1y2_q) * 64'(q1y2_q));
    s0x3_q <= apfc_pkg::fmul_rs(64'(kx2_q) * 64'(kx2_q));
    s0y3_q <= apfc_pkg::fmul_rs(64'(ky2_q) * 64'(ky2_q));
    kqx3_q <= apfc_pkg::fmul_rs(64'(vx2_q) * 64'(kx2_q));
    kqy3_q <= apfc_pkg::fmul_rs(64'(vy2_q) * 64'(ky2_q));

    q1sq4_q <= apfc_pkg::sat32(64'(s1x3_q) + 64'(s1y3_q));
    q0sq4_q <= apfc_pkg::sat32(64'(s0x3_q) + 64'(s0y3_q));
    kq4_q   <= apfc_pkg::sat32(64'(kqx3_q) + 64'(kqy3_q));

    q1sq5_q <= q1sq4_q;
    op5_q   <= apfc_pkg::sat32(-64'(apfc_pkg::sat32(64'(q0sq4_q)
               + 64'(apfc_pkg::sat32(64'(kq4_q) <<< 1)))));

    q1sq6_q <= q1sq5_q;
    opsq6_q <= apfc_pkg::fmul_rs(64'(op5_q) * 64'(op5_q));

    q1sq7_q <= q1sq6_q;
    g7_q    <= apfc_pkg::sat32(64'($signed(gam_q)) - 64'(opsq6_q));

    lin8_q  <= apfc_pkg::fmul_rs(64'(q1sq7_q) * 64'(g7_q));
    dtl9_q  <= apfc_pkg::fmul_rs(64'($signed({1'b0, dt_q})) * 64'(lin8_q));
    den10_q <= apfc_pkg::sat32(64'(apfc_pkg::ONE_Q) - 64'(dtl9_q));
  end

  // divider: index 0 is the set-up stage, index j holds j quotient bits
  logic        [31:0] d_q    [0:DB];
  logic               zero_q [0:DB];
  logic        [31:0] rr_q   [0:DB];
  logic        [31:0] ri_q   [0:DB];
  logic        [DB-1:0] wr_q [0:DB];
  logic        [DB-1:0] wi_q [0:DB];
  logic               ngr_q  [0:DB];
  logic               ngi_q  [0:DB];
  logic               pr_q   [0:DB];
  logic               mr_q   [0:DB];
  logic               pi_q   [0:DB];
  logic               mi_q   [0:DB];

  logic [31:0] dabs, nrabs, niabs;
  logic        dneg, nrneg, nineg;
  always_comb begin
    dneg  = den10_q[31];
    nrneg = nr_q[FRONT-1][31];
    nineg = ni_q[FRONT-1][31];
    dabs  = dneg  ? 32'(-den10_q)       : den10_q;
    nrabs = nrneg ? 32'(-nr_q[FRONT-1]) : nr_q[FRONT-1];
    niabs = nineg ? 32'(-ni_q[FRONT-1]) : ni_q[FRONT-1];
  end

  function automatic logic [DB+31:0] dstep(input logic [31:0] r, input logic [DB-1:0] w,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    t = {r, w[DB-1]};
    s = t - {1'b0, d};
    if (!s[32]) return {s[31:0], w[DB-2:0], 1'b1};
    return {t[31:0], w[DB-2:0], 1'b0};
  endfunction

  always_ff @(posedge clk_i) begin
    d_q[0]    <= dabs;
    zero_q[0] <= (den10_q == '0);
    rr_q[0]   <= '0;
    ri_q[0]   <= '0;
    wr_q[0]   <= {1'b0, nrabs, 16'd0} + DB'(dabs >> 1);
    wi_q[0]   <= {1'b0, niabs, 16'd0} + DB'(dabs >> 1);
    ngr_q[0]  <= nrneg ^ dneg;
    ngi_q[0]  <= nineg ^ dneg;
    pr_q[0]   <= ~nrneg & (nr_q[FRONT-1] != '0);
    mr_q[0]   <= nrneg;
    pi_q[0]   <= ~nineg & (ni_q[FRONT-1] != '0);
    mi_q[0]   <= nineg;
    for (int k = 1; k <= DB; k++) begin
      {rr_q[k], wr_q[k]} <= dstep(rr_q[k-1], wr_q[k-1], d_q[k-1]);
      {ri_q[k], wi_q[k]} <= dstep(ri_q[k-1], wi_q[k-1], d_q[k-1]);
      d_q[k]    <= d_q[k-1];
      zero_q[k] <= zero_q[k-1];
      ngr_q[k]  <= ngr_q[k-1];
      ngi_q[k]  <= ngi_q[k-1];
      pr_q[k]   <= pr_q[k-1];
      mr_q[k]   <= mr_q[k-1];
      pi_q[k]   <= pi_q[k-1];
      mi_q[k]   <= mi_q[k-1];
    end
  end

  function automatic logic signed [31:0] fin(input logic [DB-1:0] q, input logic ng,
                                             input logic z, input logic p, input logic m);
    if (z) begin
      if (p) return apfc_pkg::MAX32;
      if (m) return apfc_pkg::MIN32;
      return '0;
    end
    if (ng) begin
      if (q > DB'(33'h0_8000_0000)) return apfc_pkg::MIN32;
      return 32'(-q);
    end
    if (q > DB'(33'h0_7FFF_FFFF)) return apfc_pkg::MAX32;
    return q[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    new_amp_real_o <= fin(wr_q[DB], ngr_q[DB], zero_q[DB], pr_q[DB], mr_q[DB]);
    new_amp_imag_o <= fin(wi_q[DB], ngi_q[DB], zero_q[DB], pi_q[DB], mi_q[DB]);
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o) else $error("request lost in pipeline");
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT)) else $error("result without request");
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[1] |-> $past(fv_q[0], FRONT)) else $error("divider entry out of step");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Testbench for the spectral amplitude update: queued requests, predictor, result checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int         DRAIN_CYCLES = 80;

  typedef struct {
    bit                 is_cfg;
    logic        [1:0]  cfg_idx;
    logic        [17:0] cfg_val;
    bit                 no_idle;
    logic        [5:0]  row;
    logic        [5:0]  col;
    logic        [1:0]  mode;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] nr;
    logic signed [31:0] ni;
  } req_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } amp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [5:0] row_index_i = '0;
  logic [5:0] col_index_i = '0;
  logic [1:0] mode_select_i = '0;
  logic signed [31:0] amp_real_i = '0;
  logic signed [31:0] amp_imag_i = '0;
  logic signed [31:0] nonlin_real_i = '0;
  logic signed [31:0] nonlin_imag_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [17:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] new_amp_real_o;
  logic signed [31:0] new_amp_imag_o;

  req_t pending[$];
  amp_t amp_expected[$];
  int   errors = 0;
  bit   held = 1'b0;

  logic [15:0] dt_reg = apfc_pkg::TIME_STEP_RST;
  logic [17:0] gamma_reg = apfc_pkg::GROWTH_RST;
  logic [15:0] kstep_reg = apfc_pkg::WAVE_STEP_RST;

  apfc_spectral_amplitude_update u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .row_index_i, .col_index_i, .mode_select_i,
    .amp_real_i, .amp_imag_i, .nonlin_real_i, .nonlin_imag_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .new_amp_real_o, .new_amp_imag_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    longint unsigned n, d, q;
    bit neg;
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    n = longint'(num < 0 ? -num : num) << 16;
    d = longint'(den < 0 ? -den : den);
    q = (n + d / 2) / d;
    if (q > 64'd4294967296) q = 64'd4294967296;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint wavevec(input logic [5:0] idx);
    longint i;
    i = longint'(idx);
    if (i >= 32) i -= 64;
    return clamp32(i * longint'(kstep_reg));
  endfunction

  function automatic amp_t update_amp(input req_t r);
    longint one, half, h3, dt, gam, ky, kx, vx, vy;
    longint q1x, q1y, q1sq, q0sq, kq, op, lin, den, numr, numi;
    amp_t res;
    one = 64'sd65536;
    half = 64'sd32768;
    h3 = (64'sd929887697 + 64'sd8192) >>> 14;
    dt = longint'(dt_reg);
    gam = longint'($signed(gamma_reg));
    ky = wavevec(r.row);
    kx = wavevec(r.col);
    vx = 0;
    vy = 0;
    case (r.mode)
      apfc_pkg::MODE_K1: begin vx = -h3; vy = -half; end
      apfc_pkg::MODE_K2: begin vx = 0; vy = one; end
      apfc_pkg::MODE_K3: begin vx = h3; vy = -half; end
      default: ;
    endcase
    q1x = clamp32(kx + vx);
    q1y = clamp32(ky + vy);
    q1sq = clamp32(qmul(q1x, q1x) + qmul(q1y, q1y));
    q0sq = clamp32(qmul(kx, kx) + qmul(ky, ky));
    kq = clamp32(qmul(vx, kx) + qmul(vy, ky));
    op = clamp32(-clamp32(q0sq + clamp32(2 * kq)));
    lin = qmul(q1sq, clamp32(gam - qmul(op, op)));
    den = clamp32(one - qmul(dt, lin));
    numr = clamp32(longint'(r.ar) + qmul(dt, longint'(r.nr)));
    numi = clamp32(longint'(r.ai) + qmul(dt, longint'(r.ni)));
    res.re = 32'(qdiv(numr, den));
    res.im = 32'(qdiv(numi, den));
    return res;
  endfunction

  // driver: one assignment per signal per falling edge
  always @(negedge clk_i) begin
    req_t r;
    logic s, w;
    if (rst_ni && !held) begin
      s = 1'b0;
      w = 1'b0;
      if (pending.size() != 0) begin
        r = pending[0];
        if (r.is_cfg) begin
          if (amp_expected.size() == 0 && !start_i) begin
            w = 1'b1;
            cfg_idx_i <= r.cfg_idx;
            cfg_data_i <= r.cfg_val;
            void'(pending.pop_front());
          end
        end else if (r.no_idle || $urandom_range(99) >= 18) begin
          s = 1'b1;
          row_index_i <= r.row;
          col_index_i <= r.col;
          mode_select_i <= r.mode;
          amp_real_i <= r.ar;
          amp_imag_i <= r.ai;
          nonlin_real_i <= r.nr;
          nonlin_imag_i <= r.ni;
          void'(pending.pop_front());
        end
      end
      start_i <= s;
      cfg_we_i <= w;
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    amp_t e;
    req_t r;
    if (rst_ni) begin
      if (done_o) begin
        if (amp_expected.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h", $time, new_amp_real_o, new_amp_imag_o);
          errors++;
        end else begin
          e = amp_expected.pop_front();
          if (new_amp_real_o !== e.re) begin
            $display("%0t: new_amp_real expected %h actual %h", $time, e.re, new_amp_real_o);
            errors++;
          end
          if (new_amp_imag_o !== e.im) begin
            $display("%0t: new_amp_imag expected %h actual %h", $time, e.im, new_amp_imag_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        r.row = row_index_i;
        r.col = col_index_i;
        r.mode = mode_select_i;
        r.ar = amp_real_i;
        r.ai = amp_imag_i;
        r.nr = nonlin_real_i;
        r.ni = nonlin_imag_i;
        amp_expected.push_back(update_amp(r));
      end
      held <= start_i && busy_o;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          apfc_pkg::REG_TIME_STEP: dt_reg = cfg_data_i[15:0];
          apfc_pkg::REG_GROWTH:    gamma_reg = cfg_data_i;
          apfc_pkg::REG_WAVE_STEP: kstep_reg = cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      3: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cfg(input logic [1:0] idx, input logic [17:0] val);
    req_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    pending.push_back(r);
  endtask

  task automatic add_item(input logic [5:0] row, input logic [5:0] col, input logic [1:0] mode,
                          input logic signed [31:0] ar, input logic signed [31:0] ai,
                          input logic signed [31:0] nr, input logic signed [31:0] ni,
                          input bit no_idle);
    req_t r;
    r = '{default: '0};
    r.row = row; r.col = col; r.mode = mode;
    r.ar = ar; r.ai = ai; r.nr = nr; r.ni = ni;
    r.no_idle = no_idle;
    pending.push_back(r);
  endtask

  task automatic add_random(input int n, input bit no_idle);
    repeat (n) add_item(6'($urandom), 6'($urandom), 2'($urandom),
                        pick32(), pick32(), pick32(), pick32(), no_idle);
  endtask

  task automatic add_phase(input logic [15:0] dt, input logic [17:0] g, input logic [15:0] ks);
    add_cfg(apfc_pkg::REG_TIME_STEP, {2'b0, dt});
    add_cfg(apfc_pkg::REG_GROWTH, g);
    add_cfg(apfc_pkg::REG_WAVE_STEP, {2'b0, ks});
  endtask

  initial begin
    // defaults: index extremes, every mode including the unused one
    add_item(6'd0, 6'd0, apfc_pkg::MODE_K1, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_item(6'd63, 6'd63, apfc_pkg::MODE_K2, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_item(6'd31, 6'd32, apfc_pkg::MODE_K3, 32'sd65536, -32'sd65536, 32'sd1, -32'sd1, 1'b0);
    add_item(6'd32, 6'd31, MODE_NONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_item(6'h2A, 6'h15, apfc_pkg::MODE_K2, 32'sh5555_5555, 32'shAAAA_AAAA,
             32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
    add_random(300, 1'b0);
    // zero denominator: mode k1/k3 at the origin with dt ~ 1 and Gamma = 1
    add_phase(16'd65535, 18'sd65536, 16'd0);
    add_item(6'd0, 6'd0, apfc_pkg::MODE_K1, 32'sd100, -32'sd100, 32'sd0, 32'sd0, 1'b0);
    add_item(6'd0, 6'd0, apfc_pkg::MODE_K3, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_item(6'd5, 6'd9, apfc_pkg::MODE_K3, -32'sd7, 32'sd7, 32'sd3, -32'sd3, 1'b0);
    add_item(6'd0, 6'd0, apfc_pkg::MODE_K2, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sd65536, -32'sd65536, 1'b0);
    add_item(6'd0, 6'd0, MODE_NONE, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_random(300, 1'b0);
    add_phase(16'd0, -18'sd65536, 16'd65535);
    add_item(6'd31, 6'd33, apfc_pkg::MODE_K1, 32'sd12345, -32'sd12345,
             32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_random(300, 1'b0);
    add_phase(16'd65535, 18'sd0, 16'd1);
    add_random(300, 1'b0);
    add_phase(16'($urandom), 18'($signed($urandom_range(131072)) - 65536),
              16'($urandom_range(8192)));
    add_random(350, 1'b1);
    add_phase(16'($urandom), 18'($signed($urandom_range(131072)) - 65536), 16'($urandom));
    add_random(300, 1'b0);
    add_phase(apfc_pkg::TIME_STEP_RST, apfc_pkg::GROWTH_RST, apfc_pkg::WAVE_STEP_RST);
    add_random(100, 1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending.size() != 0 || start_i) @(posedge clk_i);
    while (amp_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
